// File: hw/rtl/tcce_pkg.sv
// Constants, types and address helpers for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int ROWS     = 25;
  localparam int COLS     = 80;
  localparam int TAB_STEP = 4;
  localparam int CELLS    = ROWS * COLS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int WORD_W = 16;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [WORD_W-1:0] BLANK_RESET = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;

  typedef enum logic [1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_SETCUR = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic {
    REG_TEXT_ATTRIBUTE = 1'b0,
    REG_BLANK_CELL     = 1'b1
  } reg_index_t;

  localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;

  // first address of a physical row
  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] prow);
    return ADDR_W'(32'(prow) * COLS);
  endfunction

  // logical row is rotated by the top-row pointer
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [ROW_W:0] prow;
    prow = {1'b0, top} + {1'b0, row};
    if (prow >= (ROW_W+1)'(ROWS)) begin
      prow = prow - (ROW_W+1)'(ROWS);
    end
    return row_base(prow[ROW_W-1:0]) + ADDR_W'(col);
  endfunction

endpackage

// File: hw/rtl/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/text_console_cursor_engine_core.sv
// Top level of the text console engine: cell store, cursor and command sequencer.
`timescale 1ns / 1ps

// channel  | signals                                          | dir
// -------- | ------------------------------------------------ | ---
// in       | in_valid/in_ready, func, char_code, target_*     | in
// out      | out_valid/out_ready, cursor_*, read_word, scrolled| out
// cfg      | cfg_we, cfg_index, cfg_data                      | in
//
// Set cursor and put character: the result passes EXEC and DONE before it is registered
// on the outputs; read cell also passes RDWAIT (RAM read). in_ready stays low until then.
// A scroll rewrites the bottom row through the single RAM write port.
// Clear sweeps every cell.
// After reset a clearing pass over every cell runs before the first word.
// A word is taken while a result waits; the next result then holds in_ready low.

module text_console_cursor_engine_core
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ROW_W-1:0]  target_row,
  input  logic [COL_W-1:0]  target_col,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ROW_W-1:0]  cursor_row,
  output logic [COL_W-1:0]  cursor_col,
  output logic [WORD_W-1:0] read_word,
  output logic              scrolled,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_FILL   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [ATTR_W-1:0] text_attribute;
  logic [WORD_W-1:0] blank_cell;

  logic [ROW_W-1:0] cur_row, top;
  logic [COL_W-1:0] cur_col;

  func_t            it_func;
  logic [CHAR_W-1:0] it_char;
  logic [ROW_W-1:0] it_row;
  logic [COL_W-1:0] it_col;

  logic [ADDR_W-1:0] fill_addr, fill_end;
  logic [WORD_W-1:0] fill_word;
  logic              fill_result;

  logic [WORD_W-1:0] res_word;
  logic              res_scrolled;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // put-character cursor step
  logic [ROW_W:0]  row_t;
  logic [COL_W:0]  col_t;
  logic            printable, do_scroll;
  logic [ROW_W-1:0] top_next;
  logic            out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign printable = !it_char[CHAR_W-1] && (it_char >= CH_SPACE);
  assign top_next = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;

  always_comb begin
    row_t = {1'b0, cur_row};
    col_t = {1'b0, cur_col};
    priority if (it_char == CH_BS) begin
      if (cur_col != '0) begin
        col_t = col_t - 1'b1;
      end
    end else if (it_char == CH_TAB) begin
      col_t = (col_t + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
    end else if (it_char == CH_CR) begin
      col_t = '0;
    end else if (it_char == CH_LF) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end else if (printable) begin
      col_t = col_t + 1'b1;
    end
    if (col_t >= (COL_W+1)'(COLS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    do_scroll = 1'b0;
    if (row_t >= (ROW_W+1)'(ROWS)) begin
      do_scroll = 1'b1;
      row_t = (ROW_W+1)'(ROWS - 1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_addr;
    ram_wdata = fill_word;
    ram_raddr = cell_addr(top, it_row, it_col);
    if (state == S_FILL) begin
      ram_we = 1'b1;
    end else if (state == S_EXEC && it_func == FUNC_PUT && printable) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr(top, cur_row, cur_col);
      ram_wdata = {text_attribute, it_char};
    end
  end

  tcce_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_FILL: begin
        if (fill_addr == fill_end) begin
          state_next = fill_result ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (it_func)
          FUNC_PUT:    state_next = do_scroll ? S_FILL : S_DONE;
          FUNC_SETCUR: state_next = S_DONE;
          FUNC_CLEAR:  state_next = S_FILL;
          FUNC_READ:   state_next = S_RDWAIT;
          default:     state_next = S_DONE;
        endcase
      end
      S_RDWAIT: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_FILL;
      text_attribute <= ATTR_RESET;
      blank_cell     <= BLANK_RESET;
      cur_row        <= '0;
      cur_col        <= '0;
      top            <= '0;
      fill_addr      <= '0;
      fill_end       <= ADDR_W'(CELLS - 1);
      fill_word      <= BLANK_RESET;
      fill_result    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_TEXT_ATTRIBUTE: text_attribute <= cfg_data[ATTR_W-1:0];
          REG_BLANK_CELL:     blank_cell     <= cfg_data;
          default:            ;
        endcase
      end

      if (state == S_FILL) begin
        fill_addr <= fill_addr + 1'b1;
      end

      if (state == S_EXEC) begin
        fill_word   <= blank_cell;
        fill_result <= 1'b1;
        unique case (it_func)
          FUNC_PUT: begin
            cur_row <= row_t[ROW_W-1:0];
            cur_col <= col_t[COL_W-1:0];
            if (do_scroll) begin
              // old top row becomes the new bottom row
              top       <= top_next;
              fill_addr <= row_base(top);
              fill_end  <= row_base(top) + ADDR_W'(COLS - 1);
            end
          end
          FUNC_SETCUR: begin
            cur_row <= it_row;
            cur_col <= it_col;
          end
          FUNC_CLEAR: begin
            cur_row   <= '0;
            cur_col   <= '0;
            top       <= '0;
            fill_addr <= '0;
            fill_end  <= ADDR_W'(CELLS - 1);
          end
          FUNC_READ: ;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_func <= func_t'(func);
      it_char <= char_code;
      it_row  <= (target_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : target_row;
      it_col  <= (target_col > COL_W'(COLS - 1)) ? COL_W'(COLS - 1) : target_col;
    end
    if (state == S_EXEC) begin
      res_word     <= '0;
      res_scrolled <= (it_func == FUNC_PUT) && do_scroll;
    end
    if (state == S_RDWAIT) begin
      res_word <= ram_rdata;
    end
    if (out_load) begin
      cursor_row <= cur_row;
      cursor_col <= cur_col;
      read_word  <= res_word;
      scrolled   <= res_scrolled;
    end
  end

endmodule

// File: verif/tcce_screen_checker.sv
// Checker for the text console engine: tracks the screen and cursor and checks each result word.
`timescale 1ns / 1ps

module tcce_screen_checker
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        func,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ROW_W-1:0]  target_row,
  input  logic [COL_W-1:0]  target_col,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [ROW_W-1:0]  cursor_row,
  input  logic [COL_W-1:0]  cursor_col,
  input  logic [WORD_W-1:0] read_word,
  input  logic              scrolled,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  output int                errors,
  output int                pending
);

  typedef struct {
    int                row;
    int                col;
    logic [WORD_W-1:0] word;
    logic              scroll;
  } console_result_t;

  logic [WORD_W-1:0] screen [CELLS];
  int                cur_row;
  int                cur_col;
  logic [ATTR_W-1:0] attr;
  logic [WORD_W-1:0] blank;
  console_result_t   due_results [$];
  int                fail_count = 0;

  function automatic console_result_t apply_console_word(input func_t f,
                                                         input logic [CHAR_W-1:0] ch,
                                                         input logic [ROW_W-1:0] trow,
                                                         input logic [COL_W-1:0] tcol);
    console_result_t r;
    int row_c;
    int col_c;
    row_c = (trow > ROWS - 1) ? ROWS - 1 : trow;
    col_c = (tcol > COLS - 1) ? COLS - 1 : tcol;
    r.word = '0;
    r.scroll = 1'b0;
    case (f)
      FUNC_PUT: begin
        case (ch)
          CH_BS: begin
            if (cur_col > 0) cur_col--;
          end
          CH_TAB: cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
          CH_CR: cur_col = 0;
          CH_LF: begin
            cur_col = 0;
            cur_row++;
          end
          default: begin
            if (ch >= CH_SPACE && ch <= CH_PRINT_LAST) begin
              screen[cur_row * COLS + cur_col] = {attr, ch};
              cur_col++;
            end
          end
        endcase
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i + COLS < CELLS; i++) screen[i] = screen[i + COLS];
          for (int i = (ROWS - 1) * COLS; i < CELLS; i++) screen[i] = blank;
          cur_row = ROWS - 1;
          r.scroll = 1'b1;
        end
      end
      FUNC_SETCUR: begin
        cur_row = row_c;
        cur_col = col_c;
      end
      FUNC_CLEAR: begin
        foreach (screen[i]) screen[i] = blank;
        cur_row = 0;
        cur_col = 0;
      end
      default: r.word = screen[row_c * COLS + col_c];
    endcase
    r.row = cur_row;
    r.col = cur_col;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      foreach (screen[i]) screen[i] = BLANK_RESET;
      cur_row = 0;
      cur_col = 0;
      attr = ATTR_RESET;
      blank = BLANK_RESET;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected word: row %0d col %0d word 0x%0h scrolled %0b",
                   $time, cursor_row, cursor_col, read_word, scrolled);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("cursor_row", want.row, cursor_row);
          check_field("cursor_col", want.col, cursor_col);
          check_field("read_word", want.word, read_word);
          check_field("scrolled", want.scroll, scrolled);
        end
      end
      if (in_valid && in_ready) begin
        due_results.push_back(apply_console_word(func_t'(func), char_code,
                                                 target_row, target_col));
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_TEXT_ATTRIBUTE: attr = cfg_data[ATTR_W-1:0];
          REG_BLANK_CELL:     blank = cfg_data;
        endcase
      end
    end
    errors <= fail_count;
    pending <= due_results.size();
  end

endmodule

// File: verif/text_console_cursor_engine_core_test.sv
// Testbench top for the text console engine: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps

module text_console_cursor_engine_core_test;
  import tcce_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 20000;
  localparam int SETTLE_CYCLES   = CELLS + 64;
  localparam int TAIL_CYCLES     = 200;
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 100;
  localparam int PRESSURE_PHASE  = 3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        func = FUNC_PUT;
  logic [CHAR_W-1:0] char_code = '0;
  logic [ROW_W-1:0]  target_row = '0;
  logic [COL_W-1:0]  target_col = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [WORD_W-1:0] read_word;
  logic              scrolled;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_TEXT_ATTRIBUTE;
  logic [WORD_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int words_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  always #6 clk = ~clk;

  text_console_cursor_engine_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .char_code  (char_code),
    .target_row (target_row),
    .target_col (target_col),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .read_word  (read_word),
    .scrolled   (scrolled),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tcce_screen_checker screen_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .char_code  (char_code),
    .target_row (target_row),
    .target_col (target_col),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .read_word  (read_word),
    .scrolled   (scrolled),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("text_console_cursor_engine_core_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall patterns in random spans, one long hold-off on request
  initial begin
    int mode;
    int span;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      for (int k = 0; k < span; k++) begin
        if (hold_off_req && !hold_off_done) begin
          out_ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_off_done = 1'b1;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (k % 4) != 0;
          default: out_ready <= $urandom_range(0, 4) == 0;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic [CHAR_W-1:0] rand_char();
    return CHAR_W'($urandom);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_print();
    return CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_LAST));
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return ROW_W'($urandom);
  endfunction

  function automatic logic [COL_W-1:0] rand_col();
    return COL_W'($urandom);
  endfunction

  task automatic send_word(input func_t f, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      if (!steady) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    func <= f;
    char_code <= ch;
    target_row <= r;
    target_col <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_registers(input logic [ATTR_W-1:0] attr, input logic [WORD_W-1:0] blank);
    cfg_we <= 1'b1;
    cfg_index <= REG_TEXT_ATTRIBUTE;
    cfg_data <= {8'($urandom), attr};
    @(posedge clk);
    cfg_index <= REG_BLANK_CELL;
    cfg_data <= blank;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // place the cursor, type a short string, then read the cells back
  task automatic send_text_run();
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    int n;
    r = ROW_W'($urandom_range(0, ROWS - 1));
    c = COL_W'($urandom_range(0, COLS - 1));
    n = $urandom_range(1, 6);
    send_word(FUNC_SETCUR, rand_char(), r, c);
    repeat (n) send_word(FUNC_PUT, rand_print(), rand_row(), rand_col());
    for (int i = 0; i < n; i++) send_word(FUNC_READ, rand_char(), r, c + COL_W'(i));
  endtask

  task automatic send_random_word();
    int pick;
    int kind;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 19);
    ch = rand_char();
    r = rand_row();
    c = rand_col();
    if (pick < 15) begin
      send_text_run();
    end else if (pick < 60) begin
      case (kind)
        0: ch = CH_BS;
        1: ch = CH_TAB;
        2: ch = CH_CR;
        3: ch = CH_LF;
        4: ch = CHAR_W'($urandom_range(0, CH_SPACE - 1));
        5: ch = {1'b1, 7'($urandom)};
        6: ;
        default: ch = rand_print();
      endcase
      send_word(FUNC_PUT, ch, r, c);
    end else begin
      if (kind < 14) begin
        r = (kind < 7) ? ROW_W'($urandom_range(ROWS - 3, ROWS - 1))
                       : ROW_W'($urandom_range(0, ROWS - 1));
        c = COL_W'($urandom_range(0, COLS - 1));
      end
      if (pick < 74) send_word(FUNC_SETCUR, ch, r, c);
      else if (pick < 98) send_word(FUNC_READ, ch, r, c);
      else send_word(FUNC_CLEAR, ch, r, c);
    end
  endtask

  initial begin
    logic [ATTR_W-1:0] attr;
    logic [WORD_W-1:0] blank;
    int phase_end;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      drain(SETTLE_CYCLES);
      case (p)
        0: begin
          attr = ATTR_RESET;
          blank = BLANK_RESET;
        end
        1: begin
          attr = '0;
          blank = '0;
        end
        2: begin
          attr = '1;
          blank = '1;
        end
        default: begin
          attr = ATTR_W'($urandom);
          blank = WORD_W'($urandom);
        end
      endcase
      set_registers(attr, blank);
      steady = (p == PRESSURE_PHASE);
      hold_off_req = (p == PRESSURE_PHASE);
      if (p == 0) begin
        send_word(FUNC_READ, rand_char(), '0, '0);
        send_word(FUNC_READ, rand_char(), '1, '1);
        send_word(FUNC_PUT, CH_PRINT_LAST, rand_row(), rand_col());
        send_word(FUNC_PUT, CH_SPACE, rand_row(), rand_col());
        send_word(FUNC_PUT, CH_SPACE - 8'd1, rand_row(), rand_col());
        send_word(FUNC_PUT, CH_PRINT_LAST + 8'd1, rand_row(), rand_col());
        send_word(FUNC_PUT, '1, rand_row(), rand_col());
        send_word(FUNC_PUT, '0, rand_row(), rand_col());
        send_word(FUNC_PUT, CH_TAB, rand_row(), rand_col());
        send_word(FUNC_PUT, CH_BS, rand_row(), rand_col());
        send_word(FUNC_PUT, CH_CR, rand_row(), rand_col());
        send_word(FUNC_PUT, CH_BS, rand_row(), rand_col());
        send_word(FUNC_READ, rand_char(), '0, '0);
        // tab off the next-to-last column wraps
        send_word(FUNC_SETCUR, rand_char(), '0, COL_W'(COLS - 2));
        send_word(FUNC_PUT, CH_TAB, rand_row(), rand_col());
        // last cell: printing wraps and scrolls
        send_word(FUNC_SETCUR, rand_char(), '1, '1);
        send_word(FUNC_PUT, rand_print(), rand_row(), rand_col());
        send_word(FUNC_READ, rand_char(), ROW_W'(ROWS - 2), COL_W'(COLS - 1));
        send_word(FUNC_PUT, CH_LF, rand_row(), rand_col());
        send_word(FUNC_SETCUR, rand_char(), ROW_W'(ROWS - 1), COL_W'(COLS - 3));
        send_word(FUNC_PUT, CH_TAB, rand_row(), rand_col());
        send_word(FUNC_CLEAR, rand_char(), rand_row(), rand_col());
        send_word(FUNC_READ, rand_char(), '1, '1);
        send_word(FUNC_SETCUR, rand_char(), ROW_W'(5), COL_W'(10));
        send_word(FUNC_READ, rand_char(), ROW_W'(5), COL_W'(10));
      end
      phase_end = words_sent + WORDS_PER_PHASE;
      while (words_sent < phase_end) send_random_word();
    end
    drain(TAIL_CYCLES);
    if (errors == 0) begin
      $display("text_console_cursor_engine_core_test: PASS");
    end else begin
      $display("text_console_cursor_engine_core_test: FAIL");
    end
    $finish;
  end

endmodule
